// ----- rtl/ngm_pkg.sv -----
// ----------------------------------------------------------------------------
// ngm_pkg: shared types and constants of the node guard monitor
// Result record, event codes, register indexes and bus identifiers.
// ----------------------------------------------------------------------------
package ngm_pkg;

	// Remote nodes with their own stamps, mask bits and assignment words.
	localparam int REMOTE_NODES = 4;
	localparam int NODE_W       = (REMOTE_NODES > 1) ? $clog2(REMOTE_NODES) : 1;

	// Configuration register indexes.
	localparam logic [2:0] REG_OWN_NODE_ID    = 3'd0;
	localparam logic [2:0] REG_LOCAL_GUARD_MS = 3'd1;
	localparam logic [2:0] REG_LOCAL_LIFE     = 3'd2;
	localparam logic [2:0] REG_HEARTBEAT      = 3'd3;
	localparam logic [2:0] REG_GUARD_MASK     = 3'd4;
	localparam logic [2:0] REG_ASSIGN_LOW     = 3'd5;
	localparam logic [2:0] REG_ASSIGN_HIGH    = 3'd6;

	// Bus identifiers and codes.
	localparam logic [10:0] COB_GUARD_BASE = 11'h700;
	localparam logic [10:0] COB_EMCY_BASE  = 11'h080;
	localparam logic [15:0] EMCY_LIFEGUARD = 16'h8130;
	localparam logic [15:0] MS_TO_US       = 16'd1000;

	typedef enum logic [2:0] {
		EV_NONE          = 3'd0,
		EV_REPLY         = 3'd1,
		EV_ALIVE         = 3'd2,
		EV_REMOTE_STATE  = 3'd3,
		EV_LOCAL_EXPIRY  = 3'd4,
		EV_REMOTE_EXPIRY = 3'd5,
		EV_RTR_REQUEST   = 3'd6
	} event_kind_t;

	typedef struct packed {
		logic [15:0] emcy_code;
		logic [2:0]  remote_index;
		logic [7:0]  tx_byte;
		logic [10:0] tx_cob_id;
		logic        status_code;
		event_kind_t event_kind;
	} result_t;

	// State code carried in a guard reply for each device mode.
	function automatic logic [6:0] nmt_state_code(input logic [1:0] mode);
		logic [6:0] code;
		unique case (mode)
			2'd0: code = 7'd0;
			2'd1: code = 7'd127;
			2'd2: code = 7'd5;
			default: code = 7'd4;
		endcase
		return code;
	endfunction

endpackage

// ----- rtl/node_guard_monitor.sv -----
// ----------------------------------------------------------------------------
// node_guard_monitor: node guarding for one device and its remote nodes
// Answers guard requests, records remote states and checks life times.
// ----------------------------------------------------------------------------
//
// Channel      Direction  Transfer when               Carries
// s_axis_*     in         s_axis_tvalid & tready      one CAN frame or one tick
// m_axis_*     out        m_axis_tvalid & tready      one result, tlast on final
// cfg_*        in         cfg_we high                 one register write
//
// A received frame passes through decode and the finish state to its result
// in the output register. A tick outside init steps through decode, three
// states for the local life time, four per remote node (a node that is not
// guarded takes one), then one to close the run. They use the single 32x16
// multiplier and the single subtract-and-compare unit that all period checks
// share, one operation each per cycle unless the sequencer waits. Reset is
// asynchronous and clears all stamps, the toggle and the alive flag. The
// sequencer waits on a new result while one pends and the output is blocked.
module node_guard_monitor
	import ngm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// now_us[31:0], frame_cob_id[42:32], frame_is_rtr[43], frame_length[47:44],
	// frame_byte0[55:48], nmt_mode[57:56], zero fill [63:58]
	input  logic [63:0] s_axis_tdata,
	// action[0]: 0 received frame, 1 timer tick
	input  logic        s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status_code[0], tx_cob_id[11:1], tx_byte[19:12], remote_index[22:20],
	// emcy_code[38:23], zero fill [39]
	output logic [39:0] m_axis_tdata,
	// event_kind[2:0]
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tlast,

	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [63:0] cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_L_MUL1,
		ST_L_MUL2,
		ST_L_CMP,
		ST_N_MUL1,
		ST_N_MUL2,
		ST_N_RESP,
		ST_N_REQ,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [6:0]   own_id_q;
	logic [15:0]  guard_ms_q;
	logic [7:0]   life_q;
	logic         heartbeat_q;
	logic [3:0]   mask_q;
	logic [127:0] assign_q;

	// Guarding state.
	logic        toggle_q;
	logic        alive_q;
	logic [31:0] local_stamp_q;
	logic [31:0] resp_stamp_q [REMOTE_NODES];
	logic [31:0] req_stamp_q  [REMOTE_NODES];

	// Captured input item.
	logic        action_q;
	logic [31:0] now_q;
	logic [10:0] cob_q;
	logic        rtr_q;
	logic [3:0]  len_q;
	logic [7:0]  byte0_q;
	logic [1:0]  mode_q;

	// Sequencer datapath.
	logic [NODE_W-1:0] node_q;
	logic [31:0]       prod_q;
	logic              gfnz_q;
	logic              rfnz_q;
	result_t           pend_q;
	logic              pend_valid_q;
	result_t           out_q;
	logic              out_valid_q;
	logic              out_last_q;

	logic s_fire;
	logic out_free;
	assign s_fire   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// Current remote node's assignment word: guard ms in 31:16, factor in 15:8.
	logic [31:0] word;
	logic [15:0] node_gt;
	logic [7:0]  node_life;
	logic [2:0]  node_num;
	assign word      = assign_q[node_q*32 +: 32];
	assign node_gt   = word[31:16];
	assign node_life = word[15:8];
	assign node_num  = 3'(node_q) + 3'd1;

	// Shared multiplier: only the low 32 bits of each product are kept.
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic [47:0] mul_full;
	always_comb begin
		unique case (state_q)
			ST_L_MUL1: mul_a = {16'd0, guard_ms_q};
			ST_N_MUL1,
			ST_N_RESP: mul_a = {16'd0, node_gt};
			default:   mul_a = prod_q;
		endcase
		unique case (state_q)
			ST_L_MUL1: mul_b = {8'd0, life_q};
			ST_N_MUL1: mul_b = {8'd0, node_life};
			default:   mul_b = MS_TO_US;
		endcase
	end
	assign mul_full = mul_a * mul_b;

	// Shared elapsed-time compare against the period in prod_q.
	logic [31:0] cmp_stamp;
	logic [31:0] elapsed;
	logic        late;
	always_comb begin
		unique case (state_q)
			ST_L_CMP:  cmp_stamp = local_stamp_q;
			ST_N_RESP: cmp_stamp = resp_stamp_q[node_q];
			default:   cmp_stamp = req_stamp_q[node_q];
		endcase
	end
	assign elapsed = now_q - cmp_stamp;
	assign late    = elapsed > prod_q;

	// A result found in a compare state; it waits in the pending slot until
	// it is known whether another result follows it.
	logic    emit_now;
	logic    stall;
	result_t new_res;
	always_comb begin
		emit_now = 1'b0;
		new_res  = '{event_kind: EV_NONE, default: '0};
		unique case (state_q)
			ST_L_CMP: begin
				emit_now          = gfnz_q && alive_q && late;
				new_res.event_kind = EV_LOCAL_EXPIRY;
				new_res.tx_cob_id  = COB_EMCY_BASE + {4'd0, own_id_q};
				new_res.emcy_code  = EMCY_LIFEGUARD;
			end
			ST_N_RESP: begin
				emit_now            = rfnz_q && late;
				new_res.event_kind   = EV_REMOTE_EXPIRY;
				new_res.tx_cob_id    = COB_EMCY_BASE + {4'd0, own_id_q};
				new_res.tx_byte      = 8'd1;
				new_res.remote_index = node_num;
				new_res.emcy_code    = EMCY_LIFEGUARD;
			end
			ST_N_REQ: begin
				emit_now            = rfnz_q && late;
				new_res.event_kind   = EV_RTR_REQUEST;
				new_res.tx_cob_id    = COB_GUARD_BASE + {8'd0, node_num};
				new_res.remote_index = node_num;
			end
			default: begin
				emit_now = 1'b0;
			end
		endcase
	end
	assign stall = emit_now && pend_valid_q && !out_free;

	// The output register takes a result when the run closes or when a new
	// result pushes the pending one out.
	logic out_load;
	assign out_load = ((state_q == ST_FINISH) && out_free) ||
		(emit_now && !stall && pend_valid_q);

	// Frame decode: the own guard request, or a state report from a node.
	logic       own_request;
	logic [6:0] frame_node;
	logic       node_bad;
	assign own_request = rtr_q && (cob_q == (COB_GUARD_BASE + {4'd0, own_id_q}));
	assign frame_node  = cob_q[6:0];
	assign node_bad    = (frame_node == 7'd0) || (frame_node > 7'(REMOTE_NODES));

	result_t frame_res;
	result_t reject_res;
	result_t quiet_res;
	always_comb begin
		reject_res             = '{event_kind: EV_NONE, default: '0};
		reject_res.status_code = 1'b1;
		quiet_res              = '{event_kind: EV_NONE, default: '0};
		frame_res              = reject_res;
		if (len_q == 4'd1) begin
			if (own_request) begin
				frame_res = quiet_res;
				if (heartbeat_q) begin
					frame_res.event_kind = EV_ALIVE;
				end else begin
					frame_res.event_kind = EV_REPLY;
					frame_res.tx_cob_id  = COB_GUARD_BASE + {4'd0, own_id_q};
					frame_res.tx_byte    = {toggle_q, nmt_state_code(mode_q)};
				end
			end else if (!node_bad) begin
				frame_res              = quiet_res;
				frame_res.event_kind   = EV_REMOTE_STATE;
				frame_res.tx_byte      = {1'b0, byte0_q[6:0]};
				frame_res.remote_index = frame_node[2:0];
			end
		end
	end

	logic last_node;
	assign last_node = (node_q == NODE_W'(REMOTE_NODES - 1));

	// The input item is held while the sequencer works on it.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			action_q <= s_axis_tuser;
			now_q    <= s_axis_tdata[31:0];
			cob_q    <= s_axis_tdata[42:32];
			rtr_q    <= s_axis_tdata[43];
			len_q    <= s_axis_tdata[47:44];
			byte0_q  <= s_axis_tdata[55:48];
			mode_q   <= s_axis_tdata[57:56];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			own_id_q      <= 7'd1;
			guard_ms_q    <= '0;
			life_q        <= '0;
			heartbeat_q   <= 1'b0;
			mask_q        <= '0;
			assign_q      <= '0;
			toggle_q      <= 1'b0;
			alive_q       <= 1'b0;
			local_stamp_q <= '0;
			for (int i = 0; i < REMOTE_NODES; i++) begin
				resp_stamp_q[i] <= '0;
				req_stamp_q[i]  <= '0;
			end
			node_q        <= '0;
			prod_q        <= '0;
			gfnz_q        <= 1'b0;
			rfnz_q        <= 1'b0;
			pend_q        <= '{event_kind: EV_NONE, default: '0};
			pend_valid_q  <= 1'b0;
			out_q         <= '{event_kind: EV_NONE, default: '0};
			out_valid_q   <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_OWN_NODE_ID:    own_id_q    <= cfg_wdata[6:0];
					REG_LOCAL_GUARD_MS: guard_ms_q  <= cfg_wdata[15:0];
					REG_LOCAL_LIFE:     life_q      <= cfg_wdata[7:0];
					REG_HEARTBEAT:      heartbeat_q <= cfg_wdata[0];
					REG_GUARD_MASK:     mask_q      <= cfg_wdata[3:0];
					REG_ASSIGN_LOW:     assign_q[63:0]   <= cfg_wdata;
					REG_ASSIGN_HIGH:    assign_q[127:64] <= cfg_wdata;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (!action_q) begin
						pend_q       <= frame_res;
						pend_valid_q <= 1'b1;
						state_q      <= ST_FINISH;
						if (len_q == 4'd1) begin
							if (own_request) begin
								alive_q       <= 1'b1;
								local_stamp_q <= now_q;
								if (!heartbeat_q) begin
									toggle_q <= !toggle_q;
								end
							end else if (!node_bad) begin
								resp_stamp_q[NODE_W'(frame_node - 7'd1)] <= now_q;
							end
						end
					end else if (mode_q == 2'd0) begin
						pend_q       <= reject_res;
						pend_valid_q <= 1'b1;
						state_q      <= ST_FINISH;
					end else begin
						state_q <= ST_L_MUL1;
					end
				end
				ST_L_MUL1: begin
					prod_q  <= mul_full[31:0];
					state_q <= ST_L_MUL2;
				end
				ST_L_MUL2: begin
					prod_q  <= mul_full[31:0];
					gfnz_q  <= (prod_q != '0);
					state_q <= ST_L_CMP;
				end
				ST_L_CMP: begin
					if (!stall) begin
						if (emit_now) begin
							alive_q <= 1'b0;
						end
						node_q  <= '0;
						state_q <= ST_N_MUL1;
					end
				end
				ST_N_MUL1: begin
					if (mask_q[node_q]) begin
						prod_q  <= mul_full[31:0];
						state_q <= ST_N_MUL2;
					end else if (last_node) begin
						state_q <= ST_FINISH;
					end else begin
						node_q <= node_q + 1'b1;
					end
				end
				ST_N_MUL2: begin
					prod_q  <= mul_full[31:0];
					rfnz_q  <= (prod_q != '0);
					state_q <= ST_N_RESP;
				end
				ST_N_RESP: begin
					if (!stall) begin
						// Request interval in the multiplier while we compare.
						prod_q <= mul_full[31:0];
						if (emit_now) begin
							resp_stamp_q[node_q] <= now_q;
						end
						state_q <= ST_N_REQ;
					end
				end
				ST_N_REQ: begin
					if (!stall) begin
						if (emit_now) begin
							req_stamp_q[node_q] <= now_q;
						end
						if (last_node) begin
							state_q <= ST_FINISH;
						end else begin
							node_q  <= node_q + 1'b1;
							state_q <= ST_N_MUL1;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_q        <= pend_valid_q ? pend_q : quiet_res;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// A new result displaces the pending one, which is then known
			// not to be the last of the run.
			if (emit_now && !stall) begin
				if (pend_valid_q) begin
					out_q       <= pend_q;
					out_last_q  <= 1'b0;
				end
				pend_q       <= new_res;
				pend_valid_q <= 1'b1;
			end
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_q.event_kind;
	assign m_axis_tdata  = {1'b0, out_q.emcy_code, out_q.remote_index, out_q.tx_byte,
		out_q.tx_cob_id, out_q.status_code};

`ifndef ASSERT_OFF
	a_fire_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> state_q == ST_DECODE)
		else $error("accepted item did not enter decode");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("pending result left behind in idle");

	a_alive_from_frame: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(alive_q) |-> $past(state_q) == ST_DECODE)
		else $error("alive flag set outside frame decode");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> state_q == $past(state_q) && node_q == $past(node_q))
		else $error("sequencer moved while the output was blocked");
`endif

endmodule

// ----- verif/node_guard_monitor_checker.sv -----
// ----------------------------------------------------------------------------
// node_guard_monitor_checker: result predictor and scoreboard
// Watches the configuration port and both stream channels of the node guard
// monitor, predicts the results of every accepted input and compares each
// output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module node_guard_monitor_checker
	import ngm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	input  logic        s_axis_tuser,

	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,

	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [63:0] cfg_wdata,

	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] NMT_INIT      = 2'd0;
	localparam logic [3:0] SINGLE_BYTE   = 4'd1;
	localparam logic [7:0] MISSING_FLAG  = 8'd1;
	// State code sent in a guard reply, indexed by the device mode.
	localparam logic [6:0] REPLY_STATE [4] = '{7'd0, 7'd127, 7'd5, 7'd4};

	typedef struct packed {
		logic    last;
		result_t res;
	} guard_result_t;

	guard_result_t expected_q[$];

	// Shadow copies of the configuration registers.
	logic [6:0]  own_id;
	logic [15:0] local_guard_ms;
	logic [7:0]  local_life;
	logic        heartbeat_on;
	logic [3:0]  guard_mask;
	logic [63:0] assign_low;
	logic [63:0] assign_high;

	// Shadow copies of the guarding state.
	logic        toggle;
	logic        local_alive;
	logic [31:0] local_stamp;
	logic [31:0] response_stamp [REMOTE_NODES];
	logic [31:0] request_stamp  [REMOTE_NODES];

	task automatic note_result(input event_kind_t kind, input logic status,
			input logic [10:0] cob, input logic [7:0] tx, input logic [2:0] idx,
			input logic [15:0] emcy);
		guard_result_t r;
		r.last              = 1'b0;
		r.res.event_kind    = kind;
		r.res.status_code   = status;
		r.res.tx_cob_id     = cob;
		r.res.tx_byte       = tx;
		r.res.remote_index  = idx;
		r.res.emcy_code     = emcy;
		expected_q.push_back(r);
	endtask

	task automatic predict_frame(input logic [63:0] d);
		logic [31:0] now;
		logic [10:0] cob;
		logic        rtr;
		logic [3:0]  len;
		logic [7:0]  b0;
		logic [1:0]  mode;
		logic [6:0]  node;
		now  = d[31:0];
		cob  = d[42:32];
		rtr  = d[43];
		len  = d[47:44];
		b0   = d[55:48];
		mode = d[57:56];
		node = cob[6:0];
		if (len != SINGLE_BYTE) begin
			note_result(EV_NONE, 1'b1, '0, '0, '0, '0);
		end else if (rtr && cob == COB_GUARD_BASE + {4'd0, own_id}) begin
			// Guard request addressed to this device.
			local_alive = 1'b1;
			local_stamp = now;
			if (heartbeat_on) begin
				note_result(EV_ALIVE, 1'b0, '0, '0, '0, '0);
			end else begin
				note_result(EV_REPLY, 1'b0, COB_GUARD_BASE + {4'd0, own_id},
						{toggle, REPLY_STATE[mode]}, '0, '0);
				toggle = ~toggle;
			end
		end else if (node == 7'd0 || node > REMOTE_NODES) begin
			note_result(EV_NONE, 1'b1, '0, '0, '0, '0);
		end else begin
			response_stamp[node - 7'd1] = now;
			note_result(EV_REMOTE_STATE, 1'b0, '0, {1'b0, b0[6:0]}, node[2:0], '0);
		end
	endtask

	task automatic predict_tick(input logic [63:0] d);
		logic [31:0] now;
		logic [1:0]  mode;
		logic [31:0] life_span;
		logic [31:0] word;
		logic [31:0] guard;
		logic [31:0] remote_span;
		int          first;
		now   = d[31:0];
		mode  = d[57:56];
		first = expected_q.size();
		if (mode == NMT_INIT) begin
			note_result(EV_NONE, 1'b1, '0, '0, '0, '0);
			return;
		end
		life_span = {16'd0, local_guard_ms} * {24'd0, local_life};
		if (life_span != 0 && local_alive) begin
			if (now - local_stamp > 32'(MS_TO_US) * life_span) begin
				local_alive = 1'b0;
				note_result(EV_LOCAL_EXPIRY, 1'b0, COB_EMCY_BASE + {4'd0, own_id},
						'0, '0, EMCY_LIFEGUARD);
			end
		end
		for (int i = 0; i < REMOTE_NODES; i++) begin
			if (!guard_mask[i])
				continue;
			word = (i < 2) ? assign_low[32*(i%2) +: 32] : assign_high[32*(i%2) +: 32];
			guard       = {16'd0, word[31:16]};
			remote_span = guard * {24'd0, word[15:8]};
			if (remote_span == 0)
				continue;
			if (now - response_stamp[i] > 32'(MS_TO_US) * remote_span) begin
				response_stamp[i] = now;
				note_result(EV_REMOTE_EXPIRY, 1'b0, COB_EMCY_BASE + {4'd0, own_id},
						MISSING_FLAG, 3'(i + 1), EMCY_LIFEGUARD);
			end
			if (now - request_stamp[i] > 32'(MS_TO_US) * guard) begin
				request_stamp[i] = now;
				note_result(EV_RTR_REQUEST, 1'b0, COB_GUARD_BASE + 11'(i + 1),
						'0, 3'(i + 1), '0);
			end
		end
		if (expected_q.size() == first)
			note_result(EV_NONE, 1'b0, '0, '0, '0, '0);
	endtask

	function automatic void check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
			mismatches++;
		end
	endfunction

	task automatic compare_result();
		guard_result_t want;
		if (expected_q.size() == 0) begin
			$error("result with nothing expected: event_kind %0d", m_axis_tuser);
			mismatches++;
			return;
		end
		want = expected_q.pop_front();
		check_field("event_kind",   want.res.event_kind,   m_axis_tuser);
		check_field("status_code",  want.res.status_code,  m_axis_tdata[0]);
		check_field("tx_cob_id",    want.res.tx_cob_id,    m_axis_tdata[11:1]);
		check_field("tx_byte",      want.res.tx_byte,      m_axis_tdata[19:12]);
		check_field("remote_index", want.res.remote_index, m_axis_tdata[22:20]);
		check_field("emcy_code",    want.res.emcy_code,    m_axis_tdata[38:23]);
		check_field("last_item",    want.last,             m_axis_tlast);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			mismatches     = 0;
			own_id         = 7'd1;
			local_guard_ms = '0;
			local_life     = '0;
			heartbeat_on   = 1'b0;
			guard_mask     = '0;
			assign_low     = '0;
			assign_high    = '0;
			toggle         = 1'b0;
			local_alive    = 1'b0;
			local_stamp    = '0;
			for (int i = 0; i < REMOTE_NODES; i++) begin
				response_stamp[i] = '0;
				request_stamp[i]  = '0;
			end
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				compare_result();
			if (cfg_we) begin
				case (cfg_addr)
					REG_OWN_NODE_ID:    own_id         = cfg_wdata[6:0];
					REG_LOCAL_GUARD_MS: local_guard_ms = cfg_wdata[15:0];
					REG_LOCAL_LIFE:     local_life     = cfg_wdata[7:0];
					REG_HEARTBEAT:      heartbeat_on   = cfg_wdata[0];
					REG_GUARD_MASK:     guard_mask     = cfg_wdata[3:0];
					REG_ASSIGN_LOW:     assign_low     = cfg_wdata;
					REG_ASSIGN_HIGH:    assign_high    = cfg_wdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser)
					predict_tick(s_axis_tdata);
				else
					predict_frame(s_axis_tdata);
				expected_q[expected_q.size() - 1].last = 1'b1;
			end
		end
		outstanding = expected_q.size();
	end

endmodule

// ----- verif/node_guard_monitor_tb.sv -----
// ----------------------------------------------------------------------------
// node_guard_monitor_tb: top of the node guard monitor testbench
// Drives received CAN frames and timer ticks into the monitor through a run
// of configuration phases, stalls both stream channels at random, and
// reports the verdict of the checker that sits beside the block.
// ----------------------------------------------------------------------------
module node_guard_monitor_tb
	import ngm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// The tuser bit of an input transfer tells a frame from a tick.
	localparam logic       ACT_FRAME   = 1'b0;
	localparam logic       ACT_TICK    = 1'b1;

	// Device modes as carried in nmt_mode.
	localparam logic [1:0] NMT_INIT    = 2'd0;
	localparam logic [1:0] NMT_PREOP   = 2'd1;
	localparam logic [1:0] NMT_OPER    = 2'd2;
	localparam logic [1:0] NMT_STOPPED = 2'd3;

	localparam logic [3:0] LEN_NONE    = 4'd0;
	localparam logic [3:0] LEN_ONE     = 4'd1;
	localparam logic [3:0] LEN_FULL    = 4'd8;

	localparam int IDLE_PCT         = 29;
	localparam int PHASES           = 6;
	localparam int ITEMS_PER_PHASE  = 60;
	// Quiet time after the last result: a full tick walk with a margin on top.
	localparam int SETTLE_CYCLES    = 40;
	// Far beyond the slowest correct run.
	localparam int TIMEOUT_NS       = 5_000_000;

	logic        clk;
	logic        arst_n;

	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tuser;

	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [63:0] cfg_wdata;

	int          mismatches;
	int          outstanding;

	// Microsecond time stamped on every input transfer. It only moves
	// forward, except for occasional jumps to a random or a set value.
	logic [31:0] clock_us;
	// Own node number as last written, so guard requests can be aimed at it.
	logic [6:0]  own_node;
	// While set, neither side of the block is stalled.
	bit          steady_flow;

	node_guard_monitor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	node_guard_monitor_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// The result side drops tready with a chance of 29 in a hundred. All inputs
	// change on the falling edge so the block sees them settled at the rise.
	always @(negedge clk) begin
		m_axis_tready = steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Hold one input transfer on the stream until the block takes it. Random
	// idle cycles go in front of it; tvalid only drops when an idle cycle is
	// actually inserted, so back-to-back transfers keep it high throughout.
	task automatic send_item(input logic act, input logic [10:0] cob,
			input logic rtr, input logic [3:0] len, input logic [7:0] b0,
			input logic [1:0] mode);
		@(negedge clk);
		while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = act;
		s_axis_tdata  = {6'd0, mode, b0, len, rtr, cob, clock_us};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic send_tick(input logic [1:0] mode);
		send_item(ACT_TICK, '0, 1'b0, LEN_NONE, '0, mode);
	endtask

	task automatic send_frame(input logic [10:0] cob, input logic rtr,
			input logic [3:0] len, input logic [7:0] b0, input logic [1:0] mode);
		send_item(ACT_FRAME, cob, rtr, len, b0, mode);
	endtask

	// Stop sending and wait until every predicted result has come out, then
	// let a few quiet cycles pass before the configuration may change.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we    = 1'b0;
		if (idx == REG_OWN_NODE_ID)
			own_node = value[6:0];
	endtask

	// One assignment word: guard time in bits 31:16 and the life factor in
	// bits 15:8, kept short so that remote expiries and requests do happen.
	function automatic logic [31:0] short_word();
		return {16'($urandom_range(0, 4)), 8'($urandom_range(1, 3)), 8'($urandom)};
	endfunction

	task automatic write_all(input logic [6:0] own, input logic [15:0] guard_ms,
			input logic [7:0] life, input logic heartbeat, input logic [3:0] mask,
			input logic [63:0] low_words, input logic [63:0] high_words);
		write_register(REG_OWN_NODE_ID,    64'(own));
		write_register(REG_LOCAL_GUARD_MS, 64'(guard_ms));
		write_register(REG_LOCAL_LIFE,     64'(life));
		write_register(REG_HEARTBEAT,      64'(heartbeat));
		write_register(REG_GUARD_MASK,     64'(mask));
		write_register(REG_ASSIGN_LOW,     low_words);
		write_register(REG_ASSIGN_HIGH,    high_words);
	endtask

	// Each random phase runs under its own register setting; the extremes of
	// every register but the high assignment word show up in at least one phase.
	task automatic configure_phase(input int phase);
		logic [6:0] own;
		own = 7'($urandom_range(1, 127));
		case (phase)
			0: write_all(7'd1, 16'd3, 8'd2, 1'b0, 4'hF,
					{short_word(), short_word()}, {short_word(), short_word()});
			// Largest guard and life factor: the periods wrap modulo 2^32.
			1: write_all(7'd127, 16'hFFFF, 8'hFF, 1'b1, 4'hF,
					'1, {short_word(), short_word()});
			2: write_all(own, 16'd1, 8'd1, 1'b0, 4'($urandom),
					{short_word(), short_word()}, {short_word(), short_word()});
			// Zero guard time disables local life time checking.
			3: write_all(own, 16'd0, 8'hFF, 1'b0, 4'hF,
					'0, {short_word(), short_word()});
			// Nothing guarded, so the assignment words must not matter.
			4: write_all(own, 16'd4, 8'd0, 1'b1, 4'h0,
					{$urandom, $urandom}, {$urandom, $urandom});
			default: write_all(own, 16'($urandom_range(1, 5)), 8'($urandom_range(1, 4)),
					1'b0, 4'hF, {short_word(), short_word()},
					{short_word(), short_word()});
		endcase
	endtask

	// Mostly well-formed traffic: ticks, guard requests to this device and
	// state reports from the remote nodes, with random noise frames mixed in.
	task automatic random_item();
		int         pick;
		logic [6:0] node;
		logic [1:0] mode;
		mode = 2'($urandom);
		if ($urandom_range(0, 99) < 4)
			clock_us = $urandom;
		else
			clock_us += 32'($urandom_range(0, 2500));
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			if ($urandom_range(0, 9) == 0)
				mode = NMT_INIT;
			else
				mode = 2'($urandom_range(1, 3));
			// Frame fields ride along on a tick and must be ignored.
			send_item(ACT_TICK, 11'($urandom), 1'($urandom),
					4'($urandom_range(0, 8)), 8'($urandom), mode);
		end else if (pick < 55) begin
			send_frame(COB_GUARD_BASE + {4'd0, own_node}, 1'b1, LEN_ONE,
					8'($urandom), mode);
		end else if (pick < 80) begin
			if ($urandom_range(0, 7) == 0)
				node = 7'($urandom_range(5, 127));
			else
				node = 7'($urandom_range(1, REMOTE_NODES));
			send_frame({4'($urandom), node}, 1'($urandom), LEN_ONE, 8'($urandom), mode);
		end else begin
			send_frame(11'($urandom), 1'($urandom), 4'($urandom_range(0, 8)),
					8'($urandom), mode);
		end
	endtask

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACT_FRAME;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = REG_OWN_NODE_ID;
		cfg_wdata     = '0;
		clock_us      = 32'd1000;
		own_node      = 7'd1;
		steady_flow   = 1'b0;
		arst_n        = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset configuration: own node 1, all guarding off.
		send_tick(NMT_INIT);                                  // rejected in init
		send_tick(NMT_PREOP);                                 // nothing to report
		send_frame(11'h701, 1'b1, LEN_NONE, 8'h00, NMT_PREOP); // empty frame
		send_frame(11'h701, 1'b1, LEN_FULL, 8'hFF, NMT_PREOP); // full frame
		// Guard replies in every mode; the toggle flips on each one.
		send_frame(11'h701, 1'b1, LEN_ONE, 8'h00, NMT_INIT);
		send_frame(11'h701, 1'b1, LEN_ONE, 8'h00, NMT_PREOP);
		send_frame(11'h701, 1'b1, LEN_ONE, 8'h00, NMT_OPER);
		send_frame(11'h701, 1'b1, LEN_ONE, 8'h00, NMT_STOPPED);
		// A data frame on the own guard identifier is a state report of node 1.
		send_frame(11'h701, 1'b0, LEN_ONE, 8'hFF, NMT_OPER);
		send_frame(11'h000, 1'b0, LEN_ONE, 8'h12, NMT_OPER);  // node 0
		send_frame(11'h705, 1'b0, LEN_ONE, 8'h12, NMT_OPER);  // beyond the guarded nodes
		send_frame(11'h7FF, 1'b1, LEN_ONE, 8'h12, NMT_OPER);  // node 127
		// A guard request for another node is taken as its state report.
		send_frame(11'h702, 1'b1, LEN_ONE, 8'h80, NMT_OPER);
		settle();

		// Short guard times on every node, with the time about to wrap.
		write_all(7'd127, 16'd2, 8'd3, 1'b0, 4'hF,
				{16'd2, 8'd1, 8'd0, 16'd1, 8'd2, 8'd0},
				{16'd1, 8'd1, 8'd0, 16'd3, 8'd1, 8'd0});
		clock_us = 32'hFFFF_F000;
		send_frame(11'h77F, 1'b1, LEN_ONE, 8'h00, NMT_OPER);
		// Past the local life time and some of the remote periods.
		clock_us += 32'd7000;
		send_tick(NMT_OPER);
		clock_us += 32'd500;
		send_tick(NMT_STOPPED);
		send_frame(11'h181, 1'b0, LEN_ONE, 8'h55, NMT_OPER);
		settle();

		// With a heartbeat producer set, a guard request is only noted.
		write_register(REG_HEARTBEAT, 64'd1);
		send_frame(11'h77F, 1'b1, LEN_ONE, 8'h00, NMT_OPER);
		clock_us = 32'hFFFF_FFFF;
		send_tick(NMT_PREOP);

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			// One whole phase runs without idling on either side.
			steady_flow = (phase == 2);
			configure_phase(phase);
			repeat (ITEMS_PER_PHASE) random_item();
		end
		settle();

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// A hang anywhere, including a result that never arrives, ends here.
	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ngm_pkg.sv
rtl/node_guard_monitor.sv
verif/node_guard_monitor_checker.sv
verif/node_guard_monitor_tb.sv
